FILE: rtl/dbchs_pkg.sv
// Shared constants, codes and handshake types of the disk block to CHS translator.
package dbchs_pkg;

    // Geometry of a request
    localparam int BLOCK_BYTES       = 1024;
    localparam int SECTOR_BYTES      = 512;
    localparam int DEVICE_COUNT      = 10;
    localparam int DEVICES_PER_DRIVE = 5;

    localparam int BLK_SHIFT     = $clog2(BLOCK_BYTES);
    localparam int SEC_SHIFT     = $clog2(SECTOR_BYTES);
    localparam int SEC_PER_BLOCK = BLOCK_BYTES / SECTOR_BYTES;
    localparam int DEV_W         = $clog2(DEVICE_COUNT);
    localparam int REL_SEC_W     = 32 - SEC_SHIFT;

    // Divider sizing: dividend is the absolute sector (33 bits),
    // divisor is the track span, heads (5 bits) times sectors (6 bits)
    localparam int DVD_W       = 33;
    localparam int DVR_W       = 11;
    localparam int ITER_W      = $clog2(DVD_W + 1);
    localparam int DIV1_ITERS  = DVD_W;
    localparam int DIV2_ITERS  = DVR_W;

    // Opcodes
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EIO    = 2'd1;
    localparam logic [1:0] ST_EINVAL = 2'd2;
    localparam logic [1:0] ST_EOF    = 2'd3;

    // Task-file constants
    localparam logic [7:0] CMD_READ   = 8'h20;
    localparam logic [7:0] CMD_WRITE  = 8'h30;
    localparam logic [7:0] DH_FIXED   = 8'hA0;

    // Configuration register indexes
    localparam logic [2:0] CFG_DRIVE_COUNT = 3'd0;
    localparam logic [2:0] CFG_HEADS0      = 3'd1;
    localparam logic [2:0] CFG_SECTORS0    = 3'd2;
    localparam logic [2:0] CFG_PRECOMP0    = 3'd3;
    localparam logic [2:0] CFG_HEADS1      = 3'd4;
    localparam logic [2:0] CFG_SECTORS1    = 3'd5;
    localparam logic [2:0] CFG_PRECOMP1    = 3'd6;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
        logic [DVD_W-1:0]  dividend;
        logic [DVR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quotient;
        logic [DVR_W-1:0]  remainder;
    } div_rsp_t;

endpackage

FILE: rtl/dbchs_div.sv
// Restoring divider, one quotient bit per cycle, shared by both division passes.
module dbchs_div
    import dbchs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DVD_W-1:0]  quo_reg,  quo_next;
    logic [DVR_W-1:0]  rem_reg,  rem_next;
    logic [DVR_W-1:0]  dvr_reg,  dvr_next;
    logic [ITER_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVR_W:0]    partial;
    logic [DVR_W:0]    diff;
    logic              fits;

    // Bring down the next dividend bit and try the subtract
    assign partial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = partial - {1'b0, dvr_reg};
    assign fits    = (partial >= {1'b0, dvr_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvr_next  = dvr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvr_next  = req.divisor;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? diff[DVR_W-1:0] : partial[DVR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvr_reg <= dvr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/disk_block_to_chs_translate.sv
// Top level: block request checks, partition table and CHS translation.
//
//  channel     | direction | contents
//  ------------+-----------+-------------------------------------------------
//  s_axis_*    | in        | request: tuser opcode, tdata device/count/offset/
//              |           | entry base/entry sectors
//  m_axis_*    | out       | result: status, cylinder, sector, head, task file
//  cfg_*       | in        | register write: enable, index, 8-bit data
//
// A load item or a request that fails a check gives its result in the cycle after
// acceptance. A request that translates goes through a setup step, the launch of
// the shared divider, the first pass for the cylinder, a step that collects it and
// launches the second pass, the second pass for head and sector, and the
// registering of the result. One request is in flight at a time.
// Reset clears the partition table and all control state and returns the geometry
// registers to their defaults.
// A stalled result holds in the output register; the next request may be taken
// in the cycle that result is consumed.
module disk_block_to_chs_translate
    import dbchs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // request channel
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [3:0] minor_device, [19:4] byte_count, [51:20] byte_offset,
    // [83:52] entry_base, [115:84] entry_sectors, [119:116] zero
    input  logic [119:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]   s_axis_tuser,
    // result channel
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] status, [11:2] cylinder, [17:12] sector_number, [21:18] head,
    // [29:22] drive_head_byte, [37:30] command_code, [41:38] control_byte,
    // [49:42] precomp_byte, [55:50] zero
    output logic [55:0]  m_axis_tdata,
    // configuration writes
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [7:0]   cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_DIV1  = 4'b0100,
        S_DIV2  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // request fields
    logic [1:0]  opcode;
    logic [3:0]  minor_device;
    logic [15:0] byte_count;
    logic [31:0] byte_offset;
    logic [31:0] entry_base;
    logic [31:0] entry_sectors;

    assign opcode        = s_axis_tuser;
    assign minor_device  = s_axis_tdata[3:0];
    assign byte_count    = s_axis_tdata[19:4];
    assign byte_offset   = s_axis_tdata[51:20];
    assign entry_base    = s_axis_tdata[83:52];
    assign entry_sectors = s_axis_tdata[115:84];

    // configuration registers
    logic [1:0] drive_count_reg;
    logic [4:0] heads0_reg, heads1_reg;
    logic [5:0] secs0_reg, secs1_reg;
    logic [7:0] precomp0_reg, precomp1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_count_reg <= 2'd0;
            heads0_reg      <= 5'd16;
            secs0_reg       <= 6'd17;
            precomp0_reg    <= 8'd0;
            heads1_reg      <= 5'd16;
            secs1_reg       <= 6'd17;
            precomp1_reg    <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DRIVE_COUNT: drive_count_reg <= cfg_wdata[1:0];
                CFG_HEADS0:      heads0_reg      <= cfg_wdata[4:0];
                CFG_SECTORS0:    secs0_reg       <= cfg_wdata[5:0];
                CFG_PRECOMP0:    precomp0_reg    <= cfg_wdata;
                CFG_HEADS1:      heads1_reg      <= cfg_wdata[4:0];
                CFG_SECTORS1:    secs1_reg       <= cfg_wdata[5:0];
                CFG_PRECOMP1:    precomp1_reg    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // handshake
    logic in_accept;
    logic out_valid_reg, out_valid_next;

    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // partition table, one entry per minor device
    logic [31:0] pbase_reg [DEVICE_COUNT];
    logic [31:0] psize_reg [DEVICE_COUNT];
    logic [DEV_W-1:0] dev_idx;
    logic             dev_ok;

    assign dev_idx = minor_device[DEV_W-1:0];
    assign dev_ok  = ({1'b0, minor_device} < 5'(DEVICE_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEVICE_COUNT; i++)
            begin
                pbase_reg[i] <= '0;
                psize_reg[i] <= '0;
            end
        end
        else if (in_accept && opcode == OP_LOAD && dev_ok)
        begin
            pbase_reg[dev_idx] <= entry_base;
            psize_reg[dev_idx] <= entry_sectors;
        end
    end

    // accept-time checks, in priority order
    logic                 drive;
    logic [4:0]           sel_heads;
    logic [5:0]           sel_secs;
    logic [7:0]           sel_precomp;
    logic [REL_SEC_W-1:0] rel_sector;
    logic [32:0]          range_end;
    logic [32:0]          abs_sector;
    logic                 translate;
    logic [1:0]           early_status;
    logic [31:0]          part_base;
    logic [31:0]          part_size;

    assign drive       = ({1'b0, minor_device} >= 5'(DEVICES_PER_DRIVE));
    assign sel_heads   = drive ? heads1_reg   : heads0_reg;
    assign sel_secs    = drive ? secs1_reg    : secs0_reg;
    assign sel_precomp = drive ? precomp1_reg : precomp0_reg;
    assign rel_sector  = byte_offset[31:SEC_SHIFT];
    assign part_base   = pbase_reg[dev_idx];
    assign part_size   = psize_reg[dev_idx];
    assign range_end   = 33'(rel_sector) + 33'(SEC_PER_BLOCK);
    assign abs_sector  = 33'(rel_sector) + 33'(part_base);

    always_comb
    begin
        translate    = 1'b0;
        early_status = ST_OK;
        if (opcode == OP_UNKNOWN)
            early_status = ST_EINVAL;
        else if (!dev_ok)
            early_status = ST_EIO;
        else if (opcode == OP_LOAD)
            early_status = ST_OK;
        else if (byte_count != 16'(BLOCK_BYTES))
            early_status = ST_EINVAL;
        else if ({1'b0, drive} >= drive_count_reg)
            early_status = ST_EIO;
        else if (byte_offset[BLK_SHIFT-1:0] != '0)
            early_status = ST_EINVAL;
        else if (range_end > {1'b0, part_size})
            early_status = ST_EOF;
        else if (sel_heads == '0 || sel_secs == '0)
            early_status = ST_EIO;
        else
            translate = 1'b1;
    end

    // job registers, held while the divider runs
    logic                 drive_reg;
    logic                 write_reg;
    logic [4:0]           heads_reg;
    logic [5:0]           secs_reg;
    logic [7:0]           precomp_reg;
    logic [32:0]          sector_reg;
    logic [DVR_W-1:0]     span_reg;
    logic [9:0]           cyl_reg;

    // shared divider handshake
    div_req_t div_req;
    div_rsp_t div_rsp;

    // marks the first pass as launched
    logic div_busy_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            drive_reg   <= drive;
            write_reg   <= (opcode == OP_WRITE);
            heads_reg   <= sel_heads;
            secs_reg    <= sel_secs;
            precomp_reg <= sel_precomp;
            sector_reg  <= abs_sector;
        end
        // track span from the registered geometry, ahead of the first pass
        if (state_reg == S_SETUP)
            span_reg <= DVR_W'(heads_reg) * DVR_W'(secs_reg);
        if (state_reg == S_DIV1 && div_rsp.done)
            cyl_reg <= div_rsp.quotient[9:0];
    end

    // shared divider: sector / span, then (sector mod span) / sectors
    always_comb
    begin
        div_req = '0;
        if (state_reg == S_DIV1 && !div_busy_reg)
        begin
            div_req.start    = 1'b1;
            div_req.iters    = ITER_W'(DIV1_ITERS);
            div_req.dividend = sector_reg;
            div_req.divisor  = span_reg;
        end
        else if (state_reg == S_DIV1 && div_rsp.done)
        begin
            div_req.start    = 1'b1;
            div_req.iters    = ITER_W'(DIV2_ITERS);
            div_req.dividend = {div_rsp.remainder, {(DVD_W-DVR_W){1'b0}}};
            div_req.divisor  = DVR_W'(secs_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_busy_reg <= 1'b0;
        else if (state_reg == S_DIV1)
            div_busy_reg <= 1'b1;
        else
            div_busy_reg <= 1'b0;
    end

    dbchs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_accept && translate)
                    state_next = S_SETUP;
            S_SETUP:
                state_next = S_DIV1;
            S_DIV1:
                if (div_busy_reg && div_rsp.done)
                    state_next = S_DIV2;
            S_DIV2:
                if (div_rsp.done)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // result register
    logic       final_done;
    logic [3:0] head_w;

    assign final_done = (state_reg == S_DIV2) && div_rsp.done;
    assign head_w     = div_rsp.quotient[3:0];

    logic [1:0] status_reg;
    logic [9:0] cyl_out_reg;
    logic [5:0] snum_reg;
    logic [3:0] head_reg;
    logic [7:0] dh_reg;
    logic [7:0] cmd_reg;
    logic [3:0] ctrl_reg;
    logic [7:0] pc_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        if ((in_accept && !translate) || final_done)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && !translate)
        begin
            // failed checks and load items carry status alone
            status_reg  <= early_status;
            cyl_out_reg <= '0;
            snum_reg    <= '0;
            head_reg    <= '0;
            dh_reg      <= '0;
            cmd_reg     <= '0;
            ctrl_reg    <= '0;
            pc_reg      <= '0;
        end
        else if (final_done)
        begin
            status_reg  <= ST_OK;
            cyl_out_reg <= cyl_reg;
            snum_reg    <= div_rsp.remainder[5:0] + 6'd1;
            head_reg    <= head_w;
            dh_reg      <= DH_FIXED | {3'b000, drive_reg, head_w};
            cmd_reg     <= write_reg ? CMD_WRITE : CMD_READ;
            ctrl_reg    <= {heads_reg[3], 3'b000};
            pc_reg      <= precomp_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, pc_reg, ctrl_reg, cmd_reg, dh_reg,
                            head_reg, snum_reg, cyl_out_reg, status_reg};

endmodule

FILE: sim/disk_block_to_chs_translate_tb.sv
// Self-checking bench for the disk block to CHS translator: directed and random requests.
`timescale 1ns / 100ps

module disk_block_to_chs_translate_tb;
    import dbchs_pkg::*;

    // Cycles to let pass once nothing is outstanding; covers the translate path.
    localparam int DRAIN_CYCLES = 60;

    // One request as the bench sees it, before packing onto the stream.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  minor;
        logic [15:0] byte_count;
        logic [31:0] byte_offset;
        logic [31:0] entry_base;
        logic [31:0] entry_sectors;
    } block_req_t;

    // One result, laid out so that a cast of m_axis_tdata[49:0] fills it.
    typedef struct packed {
        logic [7:0] precomp;
        logic [3:0] control;
        logic [7:0] command;
        logic [7:0] drive_head;
        logic [3:0] head;
        logic [5:0] sector_number;
        logic [9:0] cylinder;
        logic [1:0] status;
    } chs_answer_t;

    // Shadow of the geometry registers and partition table, plus the answers still owed.
    class chs_ledger;
        logic [1:0]  drive_count;
        logic [4:0]  heads [2];
        logic [5:0]  sectors [2];
        logic [7:0]  precomp [2];
        logic [31:0] part_base [DEVICE_COUNT];
        logic [31:0] part_size [DEVICE_COUNT];
        chs_answer_t awaited_results [$];
        int          mismatch_count;

        function new();
            drive_count = 2'd0;
            heads       = '{5'd16, 5'd16};
            sectors     = '{6'd17, 6'd17};
            precomp     = '{8'd0, 8'd0};
            foreach (part_base[i])
            begin
                part_base[i] = '0;
                part_size[i] = '0;
            end
            mismatch_count = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [7:0] value);
            case (idx)
                CFG_DRIVE_COUNT: drive_count = value[1:0];
                CFG_HEADS0:      heads[0]    = value[4:0];
                CFG_SECTORS0:    sectors[0]  = value[5:0];
                CFG_PRECOMP0:    precomp[0]  = value;
                CFG_HEADS1:      heads[1]    = value[4:0];
                CFG_SECTORS1:    sectors[1]  = value[5:0];
                CFG_PRECOMP1:    precomp[1]  = value;
                default:         ;
            endcase
        endfunction

        // Work out the answer to one request; load items update the partition table.
        function chs_answer_t translate_request(block_req_t rq);
            chs_answer_t ans;
            int          drive;
            logic [4:0]  nh;
            logic [5:0]  ns;
            logic [63:0] abs_sector;
            logic [63:0] span;
            ans = '0;
            if (rq.opcode == OP_UNKNOWN)
            begin
                ans.status = ST_EINVAL;
                return ans;
            end
            if (rq.minor >= DEVICE_COUNT)
            begin
                ans.status = ST_EIO;
                return ans;
            end
            if (rq.opcode == OP_LOAD)
            begin
                part_base[rq.minor] = rq.entry_base;
                part_size[rq.minor] = rq.entry_sectors;
                ans.status = ST_OK;
                return ans;
            end
            if (rq.byte_count != BLOCK_BYTES)
            begin
                ans.status = ST_EINVAL;
                return ans;
            end
            drive = rq.minor / DEVICES_PER_DRIVE;
            if (drive >= drive_count)
            begin
                ans.status = ST_EIO;
                return ans;
            end
            if (rq.byte_offset % BLOCK_BYTES != 0)
            begin
                ans.status = ST_EINVAL;
                return ans;
            end
            abs_sector = 64'(rq.byte_offset / SECTOR_BYTES);
            if (abs_sector + SEC_PER_BLOCK > 64'(part_size[rq.minor]))
            begin
                ans.status = ST_EOF;
                return ans;
            end
            abs_sector = abs_sector + 64'(part_base[rq.minor]);
            nh = heads[drive];
            ns = sectors[drive];
            if (nh == 0 || ns == 0)
            begin
                ans.status = ST_EIO;
                return ans;
            end
            span = 64'(nh) * 64'(ns);
            ans.status        = ST_OK;
            ans.cylinder      = 10'(abs_sector / span);
            ans.sector_number = 6'(abs_sector % 64'(ns) + 64'd1);
            ans.head          = 4'((abs_sector % span) / 64'(ns));
            ans.drive_head    = DH_FIXED | 8'(drive << 4) | {4'b0, ans.head};
            ans.command       = (rq.opcode == OP_READ) ? CMD_READ : CMD_WRITE;
            ans.control       = 4'(nh & 5'd8);
            ans.precomp       = precomp[drive];
            return ans;
        endfunction

        function void note_request(block_req_t rq);
            awaited_results.push_back(translate_request(rq));
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(logic [55:0] word);
            chs_answer_t want;
            chs_answer_t got;
            got = chs_answer_t'(word[49:0]);
            if (awaited_results.size() == 0)
            begin
                $error("result %h arrived with no request outstanding", word);
                mismatch_count++;
                return;
            end
            want = awaited_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("cylinder", want.cylinder, got.cylinder);
            check_field("sector_number", want.sector_number, got.sector_number);
            check_field("head", want.head, got.head);
            check_field("drive_head_byte", want.drive_head, got.drive_head);
            check_field("command_code", want.command, got.command);
            check_field("control_byte", want.control, got.control);
            check_field("precomp_byte", want.precomp, got.precomp);
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [3:0] minor_device, [19:4] byte_count, [51:20] byte_offset,
    // [83:52] entry_base, [115:84] entry_sectors, [119:116] zero
    logic [119:0] s_axis_tdata;
    // [1:0] opcode
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [1:0] status, [11:2] cylinder, [17:12] sector_number, [21:18] head,
    // [29:22] drive_head_byte, [37:30] command_code, [41:38] control_byte,
    // [49:42] precomp_byte, [55:50] zero
    logic [55:0]  m_axis_tdata;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [7:0]   cfg_wdata;

    chs_ledger    ledger;
    bit           gaps_on;   // allow idle bursts on both stream sides

    // Register write order used for every geometry change.
    const logic [2:0] reg_order [7] = '{CFG_DRIVE_COUNT, CFG_HEADS0, CFG_SECTORS0,
                                        CFG_PRECOMP0, CFG_HEADS1, CFG_SECTORS1,
                                        CFG_PRECOMP1};

    disk_block_to_chs_translate dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic block_req_t block_req(logic [1:0] op, logic [3:0] minor,
                                             logic [15:0] count, logic [31:0] offset,
                                             logic [31:0] base, logic [31:0] nsec);
        block_req_t rq;
        rq.opcode        = op;
        rq.minor         = minor;
        rq.byte_count    = count;
        rq.byte_offset   = offset;
        rq.entry_base    = base;
        rq.entry_sectors = nsec;
        return rq;
    endfunction

    // Draw one random request. Most are well-formed reads and writes aimed inside
    // the partition currently loaded for the device, so the divider path gets
    // exercised; loads keep the table moving; the rest is malformed noise.
    function automatic block_req_t pick_request();
        block_req_t  rq;
        int unsigned roll;
        logic [31:0] psize;
        logic [31:0] limit;
        logic [31:0] blk;
        roll = $urandom_range(0, 99);
        rq.opcode        = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        rq.minor         = 4'($urandom_range(0, DEVICE_COUNT - 1));
        rq.byte_count    = 16'(BLOCK_BYTES);
        rq.byte_offset   = '0;
        rq.entry_base    = $urandom;
        rq.entry_sectors = $urandom;
        if (roll < 14)
        begin
            // partition load: count and offset ride along but are ignored
            rq.opcode      = OP_LOAD;
            rq.byte_count  = 16'($urandom);
            rq.byte_offset = $urandom;
            if ($urandom_range(0, 2) != 0)
                rq.entry_base = $urandom_range(0, 20000);
            case ($urandom_range(0, 7))
                0:       rq.entry_sectors = '0;
                1:       ;
                2:       rq.entry_sectors = $urandom_range(0, 6);
                default: rq.entry_sectors = $urandom_range(2, 4000000);
            endcase
        end
        else if (roll < 84)
        begin
            psize = ledger.part_size[rq.minor];
            if (psize < SEC_PER_BLOCK)
                rq.byte_offset = 32'($urandom_range(0, 63)) << BLK_SHIFT;
            else
            begin
                // highest block index that still fits, clamped to what 32 bits can address
                limit = (psize - SEC_PER_BLOCK) / SEC_PER_BLOCK;
                if (limit > 32'h003F_FFFF)
                    limit = 32'h003F_FFFF;
                case ($urandom_range(0, 9))
                    0:       blk = limit;
                    1:       blk = (limit + 1) & 32'h003F_FFFF;
                    default: blk = $urandom_range(0, limit);
                endcase
                rq.byte_offset = blk << BLK_SHIFT;
            end
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    rq.opcode      = OP_UNKNOWN;
                    rq.byte_offset = $urandom;
                end
                1:
                begin
                    rq.opcode = 2'($urandom);
                    rq.minor  = 4'($urandom_range(DEVICE_COUNT, 15));
                end
                2:       rq.byte_count = 16'($urandom);
                3:       rq.byte_offset = ($urandom & ~32'(BLOCK_BYTES - 1))
                                          | 32'($urandom_range(1, BLOCK_BYTES - 1));
                default:
                begin
                    rq.opcode      = 2'($urandom);
                    rq.minor       = 4'($urandom);
                    rq.byte_count  = 16'($urandom);
                    rq.byte_offset = $urandom;
                end
            endcase
        end
        return rq;
    endfunction

    // Present one request and hold it until the block takes it. Valid stays high
    // into the next request unless a gap is drawn.
    task automatic send_request(block_req_t rq);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.opcode;
        s_axis_tdata  <= {4'b0, rq.entry_sectors, rq.entry_base, rq.byte_offset,
                          rq.byte_count, rq.minor};
        do
            @(posedge clk);
        while (!s_axis_tready);
        ledger.note_request(rq);
    endtask

    task automatic run_random(int count);
        repeat (count) send_request(pick_request());
    endtask

    // Drop valid, wait for every owed result, then let the pipeline go quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all geometry registers back to back; only call while settled.
    task automatic apply_geometry(logic [7:0] dc, logic [7:0] h0, logic [7:0] s0,
                                  logic [7:0] p0, logic [7:0] h1, logic [7:0] s1,
                                  logic [7:0] p1);
        logic [7:0] vals [7];
        int         i;
        vals = '{dc, h0, s0, p0, h1, s1, p1};
        for (i = 0; i < 7; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_order[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            ledger.set_register(reg_order[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: take results, check them in order, and stall in short bursts.
    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                ledger.check_result(m_axis_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Hard stop: far beyond the slowest legal run of about 1400 requests.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        ledger = new();
        gaps_on = 1'b1;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_READ;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= CFG_DRIVE_COUNT;
        cfg_wdata     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry reports no drives: any well-formed read is an io error.
        send_request(block_req(OP_READ, 4'd0, 16'(BLOCK_BYTES), 32'h0, 32'h0, 32'h0));
        settle();

        // Both drives; drive 0 at the widest sectors, drive 1 at the smallest geometry.
        apply_geometry(8'd2, 8'd16, 8'd63, 8'd255, 8'd1, 8'd1, 8'd0);
        send_request(block_req(OP_LOAD, 4'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0000_1000));
        send_request(block_req(OP_LOAD, 4'd9, 16'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // out-of-range device on a load must leave the table alone
        send_request(block_req(OP_LOAD, 4'd12, 16'h0, 32'h0, 32'h5, 32'h5));
        send_request(block_req(OP_LOAD, 4'd5, 16'h0, 32'h0, 32'd100, 32'd10));
        send_request(block_req(OP_UNKNOWN, 4'd0, 16'(BLOCK_BYTES), 32'h0, 32'h0, 32'h0));
        send_request(block_req(OP_READ, 4'd0, 16'(BLOCK_BYTES), 32'h0, 32'h0, 32'h0));
        // last block of device 0, then one past it
        send_request(block_req(OP_WRITE, 4'd0, 16'(BLOCK_BYTES), 32'h001F_FC00, 32'h0, 32'h0));
        send_request(block_req(OP_READ, 4'd0, 16'(BLOCK_BYTES), 32'h0020_0000, 32'h0, 32'h0));
        send_request(block_req(OP_READ, 4'd0, 16'(BLOCK_BYTES - 1), 32'h0, 32'h0, 32'h0));
        send_request(block_req(OP_READ, 4'd0, 16'hFFFF, 32'h0, 32'h0, 32'h0));
        send_request(block_req(OP_READ, 4'd0, 16'h0, 32'h0, 32'h0, 32'h0));
        send_request(block_req(OP_READ, 4'd0, 16'(BLOCK_BYTES), 32'h0000_0200, 32'h0, 32'h0));
        // never loaded: zero size means beyond the end
        send_request(block_req(OP_READ, 4'd3, 16'(BLOCK_BYTES), 32'h0, 32'h0, 32'h0));
        send_request(block_req(OP_WRITE, 4'd15, 16'(BLOCK_BYTES), 32'h0, 32'h0, 32'h0));
        send_request(block_req(OP_READ, 4'd12, 16'(BLOCK_BYTES), 32'h0, 32'h0, 32'h0));
        // absolute sector runs past 32 bits: cylinder wraps
        send_request(block_req(OP_WRITE, 4'd9, 16'(BLOCK_BYTES), 32'hFFFF_FC00, 32'h0, 32'h0));
        send_request(block_req(OP_READ, 4'd9, 16'(BLOCK_BYTES), 32'h0, 32'h0, 32'h0));
        send_request(block_req(OP_READ, 4'd5, 16'(BLOCK_BYTES), 32'h0000_1000, 32'h0, 32'h0));
        send_request(block_req(OP_WRITE, 4'd5, 16'(BLOCK_BYTES), 32'h0000_1400, 32'h0, 32'h0));
        run_random(250);
        settle();

        // One drive only; head count above 16 gets cut to four bits.
        apply_geometry(8'd1, 8'd31, 8'd1, 8'd0, 8'd16, 8'd17, 8'd128);
        run_random(250);
        settle();

        // Zero heads on drive 0 and zero sectors on drive 1: geometry io errors.
        apply_geometry(8'd3, 8'd0, 8'd17, 8'd7, 8'd9, 8'd0, 8'd255);
        run_random(200);
        settle();

        apply_geometry(8'd2, 8'd15, 8'd31, 8'd64, 8'd31, 8'd63, 8'd200);
        run_random(300);
        settle();

        // No drives present.
        apply_geometry(8'd0, 8'd1, 8'd63, 8'd0, 8'd8, 8'd2, 8'd1);
        run_random(100);
        settle();

        // Final stretch at full rate on both sides.
        gaps_on = 1'b0;
        apply_geometry(8'd2, 8'd16, 8'd17, 8'd85, 8'd16, 8'd63, 8'd170);
        run_random(250);
        settle();

        if (ledger.mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dbchs_pkg.sv
rtl/dbchs_div.sv
rtl/disk_block_to_chs_translate.sv
sim/disk_block_to_chs_translate_tb.sv
